### rtl/fqs_pkg.sv
package fqs_pkg;

  // Number of entries the queue can hold; the row has one cell per entry.
  localparam int QUEUE_DEPTH = 16;
  localparam int DATA_W      = 32;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int PH_W        = $clog2(QUEUE_DEPTH);

  typedef enum logic [1:0] {
    CMD_PUSH = 2'd0,
    CMD_POP  = 2'd1,
    CMD_SORT = 2'd2,
    CMD_NOP  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // What a cell does at the next clock edge.
  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_LOAD,
    CELL_TAKE_RIGHT,
    CELL_MIN_RIGHT,
    CELL_MAX_LEFT
  } cell_op_t;

  typedef enum logic {
    FQS_IDLE,
    FQS_SORT
  } fsm_t;

endpackage

### rtl/fqs_cell.sv
module fqs_cell
  import fqs_pkg::*;
(
  input  logic                     clk,
  input  cell_op_t                 op,
  input  logic signed [DATA_W-1:0] load_value,
  input  logic signed [DATA_W-1:0] left_value,
  input  logic signed [DATA_W-1:0] right_value,
  output logic signed [DATA_W-1:0] value
);

  logic signed [DATA_W-1:0] value_r;
  logic signed [DATA_W-1:0] value_nxt;

  // A compare-exchange pair spans two cells; each side keeps its own half.
  always_comb begin
    value_nxt = value_r;
    case (op)
      CELL_HOLD:       value_nxt = value_r;
      CELL_LOAD:       value_nxt = load_value;
      CELL_TAKE_RIGHT: value_nxt = right_value;
      CELL_MIN_RIGHT:  value_nxt = (value_r > right_value) ? right_value : value_r;
      CELL_MAX_LEFT:   value_nxt = (left_value > value_r) ? left_value : value_r;
      default:         value_nxt = value_r;
    endcase
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

  assign value = value_r;

endmodule

### rtl/fifo_queue_with_sort_core.sv
// Bounded FIFO of signed 32-bit values with an in-place ascending sort.
// Requests arrive on the in_ channel (in_cmd, in_push_value) with a
// valid/ready handshake; every accepted request yields exactly one result on
// the out_ channel (out_status, out_pop_value, out_entry_count, out_is_empty).
// A push appends at the tail, or is refused with status full when all
// QUEUE_DEPTH entries are in use. A pop returns the oldest entry, or status
// empty and a zero value when nothing is held. The unused command code is
// answered with status ok and changes nothing.
// The result is registered and valid in the cycle after its request is taken.
// Push, pop and the unused code sustain one request per cycle while out_ready
// is high, including while an earlier result is taken in the same cycle.
// A sort is answered at once, then the row of cells runs odd-even
// transposition, one compare-exchange phase per cycle; in_ready stays low
// until the last phase is done, so no other request is taken meanwhile.
// Synchronous reset empties the queue and drops any pending result; entry
// contents are not cleared since only held entries are ever read.
// When the receiver stalls, the result holds and no further request is taken
// until it is accepted.
module fifo_queue_with_sort_core
  import fqs_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [1:0]               in_cmd,
  input  logic signed [DATA_W-1:0] in_push_value,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [1:0]               out_status,
  output logic signed [DATA_W-1:0] out_pop_value,
  output logic [CNT_W-1:0]         out_entry_count,
  output logic                     out_is_empty
);

  // Cell 0 holds the oldest entry and cell k the k-th oldest, until a sort reorders them.
  logic signed [DATA_W-1:0] cell_val [QUEUE_DEPTH];
  cell_op_t                 cell_op  [QUEUE_DEPTH];

  fsm_t             state_r, state_nxt;
  logic [PH_W-1:0]  phase_r, phase_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  logic                     out_valid_r;
  status_t                  out_status_r;
  logic signed [DATA_W-1:0] out_pop_value_r;
  logic [CNT_W-1:0]         out_entry_count_r;

  logic                     accept;
  status_t                  res_status;
  logic signed [DATA_W-1:0] res_pop_value;

  // The row of cells. Edge neighbors are tied off to zero; the first cell's
  // left input is never picked, and a pop shifts zero into the last cell.
  for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
    logic signed [DATA_W-1:0] left_v;
    logic signed [DATA_W-1:0] right_v;

    if (g == 0) begin : g_first
      assign left_v = '0;
    end else begin : g_mid_l
      assign left_v = cell_val[g-1];
    end

    if (g == QUEUE_DEPTH - 1) begin : g_last
      assign right_v = '0;
    end else begin : g_mid_r
      assign right_v = cell_val[g+1];
    end

    fqs_cell u_cell (
      .clk         (clk),
      .op          (cell_op[g]),
      .load_value  (in_push_value),
      .left_value  (left_v),
      .right_value (right_v),
      .value       (cell_val[g])
    );
  end

  // A new request is taken only when idle and the output slot is free or
  // being emptied in this cycle.
  assign in_ready = (state_r == FQS_IDLE) && (!out_valid_r || out_ready);
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_nxt     = state_r;
    phase_nxt     = phase_r;
    count_nxt     = count_r;
    res_status    = ST_OK;
    res_pop_value = '0;
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      cell_op[i] = CELL_HOLD;
    end

    case (state_r)
      FQS_IDLE: begin
        if (accept) begin
          case (cmd_t'(in_cmd))
            CMD_PUSH: begin
              if (count_r >= CNT_W'(QUEUE_DEPTH)) begin
                res_status = ST_FULL;
              end else begin
                for (int i = 0; i < QUEUE_DEPTH; i++) begin
                  if (CNT_W'(i) == count_r) begin
                    cell_op[i] = CELL_LOAD;
                  end
                end
                count_nxt = count_r + CNT_W'(1);
              end
            end
            CMD_POP: begin
              if (count_r == '0) begin
                res_status = ST_EMPTY;
              end else begin
                res_pop_value = cell_val[0];
                for (int i = 0; i < QUEUE_DEPTH; i++) begin
                  cell_op[i] = CELL_TAKE_RIGHT;
                end
                count_nxt = count_r - CNT_W'(1);
              end
            end
            CMD_SORT: begin
              state_nxt = FQS_SORT;
              phase_nxt = '0;
            end
            default: begin
            end
          endcase
        end
      end
      FQS_SORT: begin
        // Even phases pair cells (0,1),(2,3)...; odd phases (1,2),(3,4)...
        // Only pairs lying fully inside the held entries take part.
        for (int k = 0; k < QUEUE_DEPTH - 1; k++) begin
          if ((1'(k) == phase_r[0]) && (CNT_W'(k + 1) < count_r)) begin
            cell_op[k]   = CELL_MIN_RIGHT;
            cell_op[k+1] = CELL_MAX_LEFT;
          end
        end
        if (phase_r == PH_W'(QUEUE_DEPTH - 1)) begin
          state_nxt = FQS_IDLE;
          phase_nxt = '0;
        end else begin
          phase_nxt = phase_r + PH_W'(1);
        end
      end
      default: begin
        state_nxt = FQS_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= FQS_IDLE;
      phase_r <= '0;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
      count_r <= count_nxt;
    end
  end

  // Result register: loaded when a request is taken, released on out_ready.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_status_r      <= res_status;
      out_pop_value_r   <= res_pop_value;
      out_entry_count_r <= count_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_pop_value   = out_pop_value_r;
  assign out_entry_count = out_entry_count_r;
  assign out_is_empty    = (out_entry_count_r == '0);

endmodule

### rtl/fqs_checker.sv
module fqs_checker
  import fqs_pkg::*;
(
  input logic                     clk,
  input logic                     rst_n,
  input logic                     in_valid,
  input logic                     in_ready,
  input logic [1:0]               in_cmd,
  input logic                     out_valid,
  input logic                     out_ready,
  input logic [1:0]               out_status,
  input logic signed [DATA_W-1:0] out_pop_value,
  input logic [CNT_W-1:0]         out_entry_count,
  input logic                     out_is_empty
);

  // A stalled result must hold its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status)
      && $stable(out_pop_value) && $stable(out_entry_count))
    else $error("result changed while stalled");

  // The empty flag agrees with the count.
  a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_is_empty == (out_entry_count == '0)))
    else $error("empty flag disagrees with count");

  // An empty pop returns zero and leaves the queue empty.
  a_empty_pop: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_EMPTY) |-> (out_pop_value == '0)
      && (out_entry_count == '0))
    else $error("empty pop reported a value or entries");

  // A refused push only happens at full occupancy.
  a_full_push: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_FULL) |-> (out_entry_count == CNT_W'(QUEUE_DEPTH))
      && (out_pop_value == '0))
    else $error("full status without a full queue");

  // A taken sort keeps the input closed while the row runs its phases.
  a_sort_block: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_cmd == CMD_SORT) |=> !in_ready [*QUEUE_DEPTH])
    else $error("input opened during a sort");

endmodule

bind fifo_queue_with_sort_core fqs_checker u_fqs_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .in_cmd          (in_cmd),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_status      (out_status),
  .out_pop_value   (out_pop_value),
  .out_entry_count (out_entry_count),
  .out_is_empty    (out_is_empty)
);
